@@ design/rlrw_pkg.sv @@
// Shared types and constants for the rate limiter with reversal wait.
package rlrw_pkg;

  localparam int STEP_LIMIT_WIDTH = 15;
  localparam int DEAD_BAND_WIDTH  = 15;
  localparam int WAIT_TICKS_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH  = 2;
  localparam int CFG_DATA_WIDTH   = 16;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_STEP_LIMIT = 2'd0,
    REG_DEAD_BAND  = 2'd1,
    REG_WAIT_TICKS = 2'd2
  } reg_index_t;

  localparam logic [STEP_LIMIT_WIDTH-1:0] STEP_LIMIT_RESET = 15'd256;
  localparam logic [DEAD_BAND_WIDTH-1:0]  DEAD_BAND_RESET  = 15'd1;
  localparam logic [WAIT_TICKS_WIDTH-1:0] WAIT_TICKS_RESET = 16'd0;

  // two's complement direction code: -1, 0, +1
  typedef enum logic [1:0] {
    DIR_ZERO = 2'b00,
    DIR_POS  = 2'b01,
    DIR_NEG  = 2'b11
  } dir_t;

  typedef struct packed {
    logic [STEP_LIMIT_WIDTH-1:0] step_limit;
    logic [DEAD_BAND_WIDTH-1:0]  dead_band;
    logic [WAIT_TICKS_WIDTH-1:0] wait_ticks;
  } cfg_t;

endpackage

@@ design/rlrw_if.sv @@
// Channel interfaces: input samples, results and register writes.
interface rlrw_in_if #(parameter int VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] target_value;
  modport source (output valid, output target_value, input ready);
  modport sink   (input valid, input target_value, output ready);
endinterface

interface rlrw_out_if #(parameter int VALUE_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] limited_value;
  logic signed [VALUE_WIDTH-1:0] change_per_tick;
  logic signed [1:0]             direction;
  modport source (output valid, output limited_value, output change_per_tick,
                  output direction, input ready);
  modport sink   (input valid, input limited_value, input change_per_tick,
                  input direction, output ready);
endinterface

interface rlrw_cfg_if;
  logic                                   valid;
  logic                                   ready;
  logic [rlrw_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [rlrw_pkg::CFG_DATA_WIDTH-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/rlrw_cfg_regs.sv @@
// Configuration register file: step limit, dead band and wait ticks.
module rlrw_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  rlrw_cfg_if.sink           cfg,
  output rlrw_pkg::cfg_t     regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.step_limit <= rlrw_pkg::STEP_LIMIT_RESET;
      regs.dead_band  <= rlrw_pkg::DEAD_BAND_RESET;
      regs.wait_ticks <= rlrw_pkg::WAIT_TICKS_RESET;
    end else if (cfg.valid) begin
      case (rlrw_pkg::reg_index_t'(cfg.index))
        rlrw_pkg::REG_STEP_LIMIT:
          regs.step_limit <= cfg.data[rlrw_pkg::STEP_LIMIT_WIDTH-1:0];
        rlrw_pkg::REG_DEAD_BAND:
          regs.dead_band <= cfg.data[rlrw_pkg::DEAD_BAND_WIDTH-1:0];
        rlrw_pkg::REG_WAIT_TICKS:
          regs.wait_ticks <= cfg.data[rlrw_pkg::WAIT_TICKS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ design/rlrw_step.sv @@
// One tick of the limiter: slew clamp, dead band and reversal wait decision.
module rlrw_step #(
  parameter int VALUE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  rlrw_pkg::cfg_t                regs,
  input  logic signed [VALUE_WIDTH-1:0] target_value,
  input  logic signed [VALUE_WIDTH-1:0] held_output,
  input  rlrw_pkg::dir_t                held_direction,
  input  logic [COUNT_WIDTH-1:0]        zero_time_count,
  output logic signed [VALUE_WIDTH-1:0] limited_value,
  output logic signed [VALUE_WIDTH-1:0] change_per_tick,
  output rlrw_pkg::dir_t                direction,
  output logic [COUNT_WIDTH-1:0]        zero_time_count_next
);

  localparam int MW = (VALUE_WIDTH > rlrw_pkg::STEP_LIMIT_WIDTH) ?
                      VALUE_WIDTH : rlrw_pkg::STEP_LIMIT_WIDTH;
  localparam int AW = MW + 2;
  localparam int CMPW = (COUNT_WIDTH > rlrw_pkg::WAIT_TICKS_WIDTH) ?
                        COUNT_WIDTH : rlrw_pkg::WAIT_TICKS_WIDTH;
  localparam longint VMAX_L = (longint'(1) <<< (VALUE_WIDTH - 1)) - 1;
  localparam logic signed [AW-1:0] VMAX = AW'(VMAX_L);
  localparam logic signed [AW-1:0] VMIN = AW'(-VMAX_L - 1);

  logic signed [AW-1:0]   tgt_x;
  logic signed [AW-1:0]   held_x;
  logic signed [AW-1:0]   lim_x;
  logic signed [AW-1:0]   eps_x;
  logic signed [AW-1:0]   delta;
  logic signed [AW-1:0]   sum;
  logic signed [AW-1:0]   y_x;
  logic signed [AW-1:0]   diff;
  logic signed [VALUE_WIDTH-1:0] y;
  logic                   near;
  logic                   pos;
  logic                   neg;
  logic                   hold_pos;
  logic                   hold_neg;
  logic                   wait_done;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_comb begin
    tgt_x  = $signed({{(AW-VALUE_WIDTH){target_value[VALUE_WIDTH-1]}}, target_value});
    held_x = $signed({{(AW-VALUE_WIDTH){held_output[VALUE_WIDTH-1]}}, held_output});
    lim_x  = $signed({{(AW-rlrw_pkg::STEP_LIMIT_WIDTH){1'b0}}, regs.step_limit});
    eps_x  = $signed({{(AW-rlrw_pkg::DEAD_BAND_WIDTH){1'b0}}, regs.dead_band});

    delta = tgt_x - held_x;
    if (delta > lim_x) begin
      delta = lim_x;
    end else if (delta < -lim_x) begin
      delta = -lim_x;
    end

    sum = held_x + delta;
    if (sum > VMAX) begin
      y_x = VMAX;
    end else if (sum < VMIN) begin
      y_x = VMIN;
    end else begin
      y_x = sum;
    end
    y = y_x[VALUE_WIDTH-1:0];

    // change is taken before the zero forcing below
    diff = y_x - held_x;
    if (diff > VMAX) begin
      change_per_tick = VMAX[VALUE_WIDTH-1:0];
    end else if (diff < VMIN) begin
      change_per_tick = VMIN[VALUE_WIDTH-1:0];
    end else begin
      change_per_tick = diff[VALUE_WIDTH-1:0];
    end

    near = (y_x >= -eps_x) && (y_x <= eps_x);
    pos  = y_x > eps_x;
    neg  = y_x < -eps_x;
    hold_pos  = held_direction == rlrw_pkg::DIR_POS;
    hold_neg  = held_direction == rlrw_pkg::DIR_NEG;
    wait_done = CMPW'(zero_time_count) >= CMPW'(regs.wait_ticks);
    count_inc = (&zero_time_count) ? zero_time_count : zero_time_count + 1'b1;

    limited_value        = y;
    direction            = held_direction;
    zero_time_count_next = zero_time_count;
    if (near) begin
      direction            = rlrw_pkg::DIR_ZERO;
      zero_time_count_next = count_inc;
    end else if ((hold_pos && pos) || (hold_neg && neg)) begin
      zero_time_count_next = '0;
    end else if (!hold_neg && neg && wait_done) begin
      direction = rlrw_pkg::DIR_NEG;
    end else if (!hold_pos && pos && wait_done) begin
      direction = rlrw_pkg::DIR_POS;
    end else begin
      // reversal still waiting: force zero, keep direction
      limited_value        = '0;
      zero_time_count_next = count_inc;
    end
  end

endmodule

@@ design/rate_limiter_reversal_wait_core.sv @@
// Slew-rate limiter with reversal dead time. Each input beat (a signed target) is
// captured in an input register, processed by combinational logic
// against the held output, direction and near-zero counter, and written to the
// result register; one result beat per input beat, one beat per cycle sustained
// while the receiver is ready. A beat waits in the input register while the
// result stalls; the held state is written with the result. Register writes
// take effect at once and should be made only while no beat is in flight.
module rate_limiter_reversal_wait_core #(
  parameter int VALUE_WIDTH = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic  clk,
  input  logic  rst,
  rlrw_in_if.sink    sample_in,
  rlrw_out_if.source sample_out,
  rlrw_cfg_if.sink   cfg
);

  rlrw_pkg::cfg_t                regs;

  logic                          s1_valid;
  logic signed [VALUE_WIDTH-1:0] s1_target;
  logic                          advance;

  logic signed [VALUE_WIDTH-1:0] held_output;
  rlrw_pkg::dir_t                held_direction;
  logic [COUNT_WIDTH-1:0]        zero_time_count;

  logic signed [VALUE_WIDTH-1:0] limited_value_next;
  logic signed [VALUE_WIDTH-1:0] change_per_tick_next;
  rlrw_pkg::dir_t                direction_next;
  logic [COUNT_WIDTH-1:0]        zero_time_count_next;

  logic                          out_valid;
  logic signed [VALUE_WIDTH-1:0] out_limited;
  logic signed [VALUE_WIDTH-1:0] out_change;
  rlrw_pkg::dir_t                out_direction;

  rlrw_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  rlrw_step #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_step (
    .regs                 (regs),
    .target_value         (s1_target),
    .held_output          (held_output),
    .held_direction       (held_direction),
    .zero_time_count      (zero_time_count),
    .limited_value        (limited_value_next),
    .change_per_tick      (change_per_tick_next),
    .direction            (direction_next),
    .zero_time_count_next (zero_time_count_next)
  );

  assign advance         = s1_valid && (!out_valid || sample_out.ready);
  assign sample_in.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_in.ready) begin
      s1_valid <= sample_in.valid;
    end
    if (sample_in.valid && sample_in.ready) begin
      s1_target <= sample_in.target_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_output     <= '0;
      held_direction  <= rlrw_pkg::DIR_ZERO;
      zero_time_count <= '0;
    end else if (advance) begin
      held_output     <= limited_value_next;
      held_direction  <= direction_next;
      zero_time_count <= zero_time_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || sample_out.ready) begin
      out_valid <= s1_valid;
    end
    if (advance) begin
      out_limited   <= limited_value_next;
      out_change    <= change_per_tick_next;
      out_direction <= direction_next;
    end
  end

  assign sample_out.valid           = out_valid;
  assign sample_out.limited_value   = out_limited;
  assign sample_out.change_per_tick = out_change;
  assign sample_out.direction       = $signed(out_direction);

  // result register always mirrors the state it was computed into
  a_held_matches_out: assert property (@(posedge clk) disable iff (rst)
    advance |=> (held_output == out_limited) && (held_direction == out_direction))
    else $error("held state differs from emitted result");

  // a captured target waits in place until it moves on
  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !advance) |=> (s1_valid && $stable(s1_target)))
    else $error("input stage lost or changed a pending beat");

  // a stalled result stays put
  a_out_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !sample_out.ready) |=> (out_valid && $stable(out_limited)))
    else $error("result register dropped a stalled beat");

endmodule

@@ dv/rate_limiter_reversal_wait_core_test.sv @@
// Self-checking testbench for the slew-rate limiter with reversal dead time.
`timescale 1ns / 1ps

module rate_limiter_reversal_wait_core_test;

  localparam int VW          = 16;
  localparam int CW          = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_TICKS = 125;
  localparam logic [rlrw_pkg::CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [VW-1:0] level;
    logic signed [VW-1:0] change;
    rlrw_pkg::dir_t       dir;
  } tick_result_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t                            kind;
    logic [rlrw_pkg::CFG_INDEX_WIDTH-1:0] reg_idx;
    logic [rlrw_pkg::CFG_DATA_WIDTH-1:0]  reg_data;
    logic signed [VW-1:0]                 target;
    logic                                 known;
    tick_result_t                         want;
  } plan_row_t;

  logic clk;
  logic rst;

  rlrw_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  rlrw_out_if #(.VALUE_WIDTH(VW)) out_ch ();
  rlrw_cfg_if                     cfg_ch ();

  rate_limiter_reversal_wait_core #(
    .VALUE_WIDTH(VW),
    .COUNT_WIDTH(CW)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .sample_in  (in_ch),
    .sample_out (out_ch),
    .cfg        (cfg_ch)
  );

  // predictor state
  rlrw_pkg::cfg_t       cfg_shadow;
  logic signed [VW-1:0] held_level;
  rlrw_pkg::dir_t       held_dir;
  logic [CW-1:0]        near_zero_ticks;

  tick_result_t expected_ticks[$];
  plan_row_t    plan[$];
  int           error_count;
  int           idle_cycles;
  int           burst_left;
  bit           sender_bursty;
  int           swing_left;
  int           swing_mag;
  bit           swing_up;
  logic [31:0]  ready_pattern;
  int           ready_pos;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int clip_value(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic void bump_near_zero();
    if (near_zero_ticks != '1) near_zero_ticks = near_zero_ticks + 1'b1;
  endfunction

  function automatic tick_result_t slew_tick(input logic signed [VW-1:0] target);
    int lim;
    int eps;
    int diff;
    int lvl;
    int chg;
    tick_result_t r;
    lim  = int'(cfg_shadow.step_limit);
    eps  = int'(cfg_shadow.dead_band);
    diff = int'(target) - int'(held_level);
    if (diff > lim) diff = lim;
    if (diff < -lim) diff = -lim;
    lvl = clip_value(int'(held_level) + diff);
    chg = clip_value(lvl - int'(held_level));
    if (lvl >= -eps && lvl <= eps) begin
      held_dir = rlrw_pkg::DIR_ZERO;
      bump_near_zero();
    end else if (held_dir == rlrw_pkg::DIR_POS && lvl > eps) begin
      near_zero_ticks = '0;
    end else if (held_dir == rlrw_pkg::DIR_NEG && lvl < -eps) begin
      near_zero_ticks = '0;
    end else if (held_dir != rlrw_pkg::DIR_NEG && lvl < -eps &&
                 near_zero_ticks >= cfg_shadow.wait_ticks) begin
      held_dir = rlrw_pkg::DIR_NEG;
    end else if (held_dir != rlrw_pkg::DIR_POS && lvl > eps &&
                 near_zero_ticks >= cfg_shadow.wait_ticks) begin
      held_dir = rlrw_pkg::DIR_POS;
    end else begin
      // reversal still waiting: output pinned at zero
      lvl = 0;
      bump_near_zero();
    end
    held_level = lvl[VW-1:0];
    r.level    = held_level;
    r.change   = chg[VW-1:0];
    r.dir      = held_dir;
    return r;
  endfunction

  function automatic plan_row_t tick_row(input logic signed [VW-1:0] target);
    plan_row_t p;
    p        = '0;
    p.kind   = ROW_TICK;
    p.target = target;
    return p;
  endfunction

  function automatic plan_row_t known_row(input logic signed [VW-1:0] target,
                                          input logic signed [VW-1:0] level,
                                          input logic signed [VW-1:0] change,
                                          input rlrw_pkg::dir_t dir);
    plan_row_t p;
    p             = tick_row(target);
    p.known       = 1'b1;
    p.want.level  = level;
    p.want.change = change;
    p.want.dir    = dir;
    return p;
  endfunction

  function automatic plan_row_t write_row(
      input logic [rlrw_pkg::CFG_INDEX_WIDTH-1:0] idx,
      input logic [rlrw_pkg::CFG_DATA_WIDTH-1:0]  data);
    plan_row_t p;
    p          = '0;
    p.kind     = ROW_WRITE;
    p.reg_idx  = idx;
    p.reg_data = data;
    return p;
  endfunction

  // square-ish swings crossing zero, dead-band edges, and full-range noise
  function automatic logic signed [VW-1:0] pick_target();
    int v;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 5) begin
      if (swing_left == 0) begin
        swing_up   = !swing_up;
        swing_mag  = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 32767)
                                                 : $urandom_range(0, 400);
        swing_left = $urandom_range(1, 30);
      end
      swing_left = swing_left - 1;
      v = swing_up ? swing_mag : -swing_mag;
    end else if (mode < 7) begin
      v = int'(cfg_shadow.dead_band) + int'($urandom_range(0, 8)) - 4;
      if ($urandom_range(0, 1) == 1) v = -v;
    end else begin
      v = int'($urandom_range(0, 65535)) - 32768;
    end
    v = clip_value(v);
    return v[VW-1:0];
  endfunction

  function automatic int pick_setting(input int top);
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return top;
      2, 3:    return $urandom_range(1, 32);
      default: return $urandom_range(33, 600);
    endcase
  endfunction

  task automatic send_tick(input logic signed [VW-1:0] target, input logic known,
                           input tick_result_t want);
    tick_result_t r;
    int gap;
    if (sender_bursty && burst_left <= 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.target_value <= target;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = slew_tick(target);
    expected_ticks.push_back(known ? want : r);
    burst_left = burst_left - 1;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [rlrw_pkg::CFG_INDEX_WIDTH-1:0] idx,
                           input logic [rlrw_pkg::CFG_DATA_WIDTH-1:0]  data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      rlrw_pkg::REG_STEP_LIMIT:
        cfg_shadow.step_limit = data[rlrw_pkg::STEP_LIMIT_WIDTH-1:0];
      rlrw_pkg::REG_DEAD_BAND:
        cfg_shadow.dead_band  = data[rlrw_pkg::DEAD_BAND_WIDTH-1:0];
      rlrw_pkg::REG_WAIT_TICKS:
        cfg_shadow.wait_ticks = data[rlrw_pkg::WAIT_TICKS_WIDTH-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // receiver: 32-bit ready patterns, some fully open
  initial begin
    out_ch.ready = 1'b0;
    ready_pos    = 0;
    forever begin
      @(negedge clk);
      if (ready_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pattern = '1;
          1: ready_pattern = $urandom;
          2: ready_pattern = $urandom & $urandom;
          default: ready_pattern = $urandom | $urandom;
        endcase
      end
      out_ch.ready <= ready_pattern[ready_pos];
      ready_pos = (ready_pos + 1) % 32;
    end
  end

  always @(posedge clk) begin
    tick_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_ticks.size() == 0) begin
        error_count = error_count + 1;
        if (error_count <= 10)
          $display("%0t: unexpected result beat: limited %0d change %0d dir %0d",
                   $realtime, out_ch.limited_value, out_ch.change_per_tick,
                   out_ch.direction);
      end else begin
        want = expected_ticks.pop_front();
        if (out_ch.limited_value !== want.level || out_ch.change_per_tick !== want.change ||
            out_ch.direction !== want.dir) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("%0t: mismatch: limited %0d/%0d change %0d/%0d dir %0d/%0d (exp/got)",
                     $realtime, want.level, out_ch.limited_value, want.change,
                     out_ch.change_per_tick, $signed(want.dir), out_ch.direction);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rate_limiter_reversal_wait_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.target_value = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    cfg_shadow.step_limit = rlrw_pkg::STEP_LIMIT_RESET;
    cfg_shadow.dead_band  = rlrw_pkg::DEAD_BAND_RESET;
    cfg_shadow.wait_ticks = rlrw_pkg::WAIT_TICKS_RESET;
    held_level      = '0;
    held_dir        = rlrw_pkg::DIR_ZERO;
    near_zero_ticks = '0;
    error_count     = 0;
    idle_cycles     = 0;
    burst_left      = 0;
    sender_bursty   = 1'b1;
    swing_left      = 0;
    swing_mag       = 0;
    swing_up        = 1'b0;

    // reset defaults: step 256, band 1, no wait
    plan.push_back(known_row(16'sh0000, 16'sh0000, 16'sh0000, rlrw_pkg::DIR_ZERO));
    plan.push_back(known_row(16'sh7FFF, 16'sh0100, 16'sh0100, rlrw_pkg::DIR_POS));
    plan.push_back(known_row(16'sh8000, 16'sh0000, 16'shFF00, rlrw_pkg::DIR_ZERO));
    plan.push_back(write_row(rlrw_pkg::REG_STEP_LIMIT, 16'h7FFF));
    plan.push_back(known_row(16'sh8000, 16'sh8001, 16'sh8001, rlrw_pkg::DIR_NEG));
    plan.push_back(known_row(16'sh8000, 16'sh8000, 16'shFFFF, rlrw_pkg::DIR_NEG));
    plan.push_back(known_row(16'sh7FFF, 16'shFFFF, 16'sh7FFF, rlrw_pkg::DIR_ZERO));
    // reversal held off for three ticks near zero
    plan.push_back(write_row(rlrw_pkg::REG_WAIT_TICKS, 16'd3));
    plan.push_back(known_row(16'sh7FFF, 16'sh0000, 16'sh7FFF, rlrw_pkg::DIR_ZERO));
    plan.push_back(known_row(16'sh7FFF, 16'sh0000, 16'sh7FFF, rlrw_pkg::DIR_ZERO));
    plan.push_back(known_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, rlrw_pkg::DIR_POS));
    plan.push_back(known_row(16'sh8000, 16'sh0000, 16'sh8001, rlrw_pkg::DIR_ZERO));
    // zero step: output frozen
    plan.push_back(write_row(rlrw_pkg::REG_STEP_LIMIT, 16'd0));
    plan.push_back(known_row(16'sh3039, 16'sh0000, 16'sh0000, rlrw_pkg::DIR_ZERO));
    plan.push_back(write_row(rlrw_pkg::REG_DEAD_BAND, 16'h7FFF));
    plan.push_back(write_row(rlrw_pkg::REG_STEP_LIMIT, 16'd100));
    plan.push_back(tick_row(16'sh4E20));
    plan.push_back(tick_row(16'shFFFB));
    plan.push_back(write_row(rlrw_pkg::REG_DEAD_BAND, 16'd0));
    plan.push_back(write_row(rlrw_pkg::REG_WAIT_TICKS, 16'd0));
    plan.push_back(tick_row(16'sh0001));
    plan.push_back(tick_row(16'shFFFF));
    plan.push_back(tick_row(16'shFFFF));
    plan.push_back(tick_row(16'sh5555));
    plan.push_back(tick_row(16'shAAAA));
    // unknown index must leave the registers alone
    plan.push_back(write_row(REG_UNUSED, 16'h0005));
    plan.push_back(tick_row(16'sh7FFF));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        drain();
        write_reg(plan[i].reg_idx, plan[i].reg_data);
      end else begin
        send_tick(plan[i].target, plan[i].known, plan[i].want);
      end
    end

    // longest wait: reversals stay pinned at zero while the counter climbs
    drain();
    write_reg(rlrw_pkg::REG_STEP_LIMIT, 16'h7FFF);
    write_reg(rlrw_pkg::REG_DEAD_BAND, 16'd1);
    write_reg(rlrw_pkg::REG_WAIT_TICKS, 16'hFFFF);
    sender_bursty = 1'b0;
    repeat (40) send_tick(16'sh0000, 1'b0, '0);
    send_tick(16'sh03E8, 1'b0, '0);
    send_tick(16'shFC18, 1'b0, '0);
    send_tick(16'sh012C, 1'b0, '0);
    sender_bursty = 1'b1;

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      drain();
      if (ph == 0) begin
        write_reg(rlrw_pkg::REG_STEP_LIMIT, 16'd1);
        write_reg(rlrw_pkg::REG_DEAD_BAND, 16'd0);
        write_reg(rlrw_pkg::REG_WAIT_TICKS, 16'hFFFF);
      end else if (ph == 1) begin
        write_reg(rlrw_pkg::REG_STEP_LIMIT, 16'h7FFF);
        write_reg(rlrw_pkg::REG_DEAD_BAND, 16'h7FFF);
        write_reg(rlrw_pkg::REG_WAIT_TICKS, 16'd0);
      end else begin
        write_reg(rlrw_pkg::REG_STEP_LIMIT, 16'(pick_setting(32767)));
        write_reg(rlrw_pkg::REG_DEAD_BAND, 16'(pick_setting(32767)));
        write_reg(rlrw_pkg::REG_WAIT_TICKS, 16'(pick_setting(65535)));
      end
      for (int k = 0; k < PHASE_TICKS; k++) begin
        if (k == PHASE_TICKS / 2) drain();
        send_tick(pick_target(), 1'b0, '0);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0 && expected_ticks.size() == 0) begin
      $display("rate_limiter_reversal_wait_core_test: done, clean");
    end else begin
      $display("rate_limiter_reversal_wait_core_test: done, errors");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/rlrw_pkg.sv
design/rlrw_if.sv
design/rlrw_cfg_regs.sv
design/rlrw_step.sv
design/rate_limiter_reversal_wait_core.sv
dv/rate_limiter_reversal_wait_core_test.sv
